>>> src/ptt_group_floor_and_fanout_assert.svh
// Assertion macros shared by the floor-control checker
`ifndef PTT_GROUP_FLOOR_AND_FANOUT_ASSERT_SVH
`define PTT_GROUP_FLOOR_AND_FANOUT_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define PTT_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ptt check failed");
// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ptt check failed");
`endif

>>> src/ptt_pkg.sv
// Package: shared constants, codes and types of the push-to-talk floor block
`timescale 1ns / 1ps
package ptt_pkg;
	localparam int CLIENT_SLOTS_DEF = 64;
	localparam int GROUP_COUNT_DEF  = 32;
	localparam int MAX_RESULTS      = 64;
	localparam logic [15:0] TIMEOUT_RESET = 16'd300;
	localparam int GRP_W  = 5;
	localparam int SLOT_W = 8;

	localparam logic [2:0] OP_JOIN   = 3'd0;
	localparam logic [2:0] OP_BYE    = 3'd1;
	localparam logic [2:0] OP_PING   = 3'd2;
	localparam logic [2:0] OP_TALK   = 3'd3;
	localparam logic [2:0] OP_STATUS = 3'd4;
	localparam logic [2:0] OP_VOICE  = 3'd5;
	localparam logic [2:0] OP_TICK   = 3'd6;

	localparam logic [2:0] KIND_JOIN_ACK = 3'd0;
	localparam logic [2:0] KIND_PING_ACK = 3'd1;
	localparam logic [2:0] KIND_TALK_ACK = 3'd2;
	localparam logic [2:0] KIND_STAT_FWD = 3'd3;
	localparam logic [2:0] KIND_VOIC_FWD = 3'd4;

	typedef struct packed {
		logic             used;
		logic [31:0]      ident;
		logic [GRP_W-1:0] grp;
	} cell_t;

	typedef struct packed {
		logic              take;
		logic              refresh;
		logic              drop;
		logic              tick;
		logic [GRP_W-1:0]  grp;
		logic [SLOT_W-1:0] owner;
		logic [31:0]       mask;
	} floor_cmd_t;
endpackage

>>> src/ptt_cell.sv
// One client slot cell of the rotating slot ring
`timescale 1ns / 1ps
module ptt_cell import ptt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  cell_t nxt,
	output cell_t cur
);
	cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (shift) begin
			cell_q <= nxt;
		end
	end

	assign cur = cell_q;
endmodule

>>> src/ptt_floor.sv
// Per-group floor table: holder, age, target mask, tick aging
`timescale 1ns / 1ps
module ptt_floor import ptt_pkg::*; #(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
	parameter int GROUP_COUNT  = GROUP_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  floor_cmd_t       cmd,
	input  logic [15:0]      timeout,
	input  logic [GRP_W-1:0] head_grp,
	output logic             head_held,
	input  logic [GRP_W-1:0] src_grp,
	output logic             src_held,
	output logic [31:0]      src_mask
);
	localparam int GW = $clog2(GROUP_COUNT);
	localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

	logic [GROUP_COUNT-1:0] held_q;
	logic [15:0]            age_q   [GROUP_COUNT];
	logic [SW-1:0]          owner_q [GROUP_COUNT];
	logic [31:0]            mask_q  [GROUP_COUNT];

	assign head_held = held_q[head_grp[GW-1:0]];
	assign src_held  = held_q[src_grp[GW-1:0]];
	assign src_mask  = mask_q[src_grp[GW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int g = 0; g < GROUP_COUNT; g++) age_q[g] <= '0;
		end else begin
			for (int g = 0; g < GROUP_COUNT; g++) begin
				if (cmd.grp[GW-1:0] == GW'(g) && (cmd.take || cmd.refresh)) begin
					age_q[g] <= '0;
					if (cmd.take) held_q[g] <= 1'b1;
				end else if (cmd.grp[GW-1:0] == GW'(g) && cmd.drop) begin
					held_q[g] <= 1'b0;
					age_q[g]  <= '0;
				end else if (cmd.tick && held_q[g]) begin
					// saturate, then release once past the timeout
					if (age_q[g] != 16'hffff && age_q[g] >= timeout) begin
						held_q[g] <= 1'b0;
						age_q[g]  <= '0;
					end else if (age_q[g] == 16'hffff && age_q[g] > timeout) begin
						held_q[g] <= 1'b0;
						age_q[g]  <= '0;
					end else if (age_q[g] != 16'hffff) begin
						age_q[g] <= age_q[g] + 16'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			if (cmd.take && cmd.grp[GW-1:0] == GW'(g)) begin
				owner_q[g] <= cmd.owner[SW-1:0];
				mask_q[g]  <= cmd.mask;
			end else if (cmd.take && held_q[g] && owner_q[g] == cmd.owner[SW-1:0]) begin
				// holder slot got a new target mask
				mask_q[g] <= cmd.mask;
			end
		end
	end
endmodule

>>> src/ptt_group_floor_and_fanout.sv
// Push-to-talk floor control: join, bye, ping, talk, fan-out of status and voice.
// Client slots sit in a ring of CLIENT_SLOTS cells that rotates one place per cycle
// while scanning, unless a result waits on a stalled output; the head cell is examined
// and rewritten. An item that uses the table (join, bye, ping, talk, or status/voice
// on a held floor) takes one full turn of the ring and a flush state for the last
// result, longer while stalled. Tick, unknown ops and status/voice without a held
// floor finish in the cycle they are accepted. Results leave in ascending slot order.
`timescale 1ns / 1ps
module ptt_group_floor_and_fanout import ptt_pkg::*; #(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
	parameter int GROUP_COUNT  = GROUP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] client_id,
	input  logic [31:0] source_ssrc,
	input  logic [31:0] group_mask,
	input  logic        talk_on,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] assigned_id,
	output logic [5:0]  dest_slot,
	output logic        last
);
	localparam int SW  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int CW  = SW + 1;
	localparam int RCW = $clog2(MAX_RESULTS + 1);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic [RCW-1:0]   rcnt_q;
	logic             done_q;
	logic [2:0]       op_q;
	logic [31:0]      cid_q;
	logic [31:0]      gmask_q;
	logic [31:0]      fmask_q;
	logic [GRP_W-1:0] jgrp_q;
	logic [15:0]      timeout_q;

	logic        pv_q;
	logic [2:0]  pkind_q;
	logic [31:0] pid_q;
	logic [5:0]  pslot_q;

	logic        ov_q;
	logic [2:0]  okind_q;
	logic [31:0] oid_q;
	logic [5:0]  oslot_q;
	logic        olast_q;

	cell_t      ring [CLIENT_SLOTS];
	cell_t      head, mod_c;
	floor_cmd_t cmd;
	logic       head_held, src_held, src_in;
	logic [31:0] src_mask;
	logic [SW-1:0] idx;
	logic       accept, out_free, match, hit, step, load_out;
	logic [2:0] hkind;
	logic [31:0] hid;
	logic [15:0] jrem;
	logic [GRP_W-1:0] jgrp_c;
	logic [SLOT_W-1:0] idx_w;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;
	assign head     = ring[0];
	assign idx      = cnt_q[SW-1:0];
	assign idx_w    = SLOT_W'(idx);
	assign src_in   = (source_ssrc[31:24] < 8'(GROUP_COUNT));

	// group of a joining client: top byte mod GROUP_COUNT, restoring subtraction
	always_comb begin
		jrem = {8'd0, client_id[31:24]};
		for (int k = 7; k >= 0; k--) begin
			if (jrem >= (16'(GROUP_COUNT) << k)) jrem = jrem - (16'(GROUP_COUNT) << k);
		end
		jgrp_c = jrem[GRP_W-1:0];
	end

	assign match = head.used && head.ident == cid_q;

	always_comb begin
		hit   = 1'b0;
		hkind = KIND_JOIN_ACK;
		hid   = '0;
		mod_c = head;
		unique case (op_q)
			OP_JOIN: begin
				hit   = !head.used;
				hid   = {cid_q[31:24], 24'(idx)};
				if (!done_q && !head.used) begin
					mod_c.used  = 1'b1;
					mod_c.ident = {cid_q[31:24], 24'(idx)};
					mod_c.grp   = jgrp_q;
				end
			end
			OP_BYE: begin
				if (match) mod_c.used = 1'b0;
			end
			OP_PING: begin
				hit   = match;
				hkind = KIND_PING_ACK;
				hid   = head.ident;
			end
			OP_TALK: begin
				hit   = match && !head_held;
				hkind = KIND_TALK_ACK;
				hid   = head.ident;
			end
			OP_STATUS: begin
				hit   = head.used && fmask_q[head.grp];
				hkind = KIND_STAT_FWD;
			end
			OP_VOICE: begin
				hit   = head.used && fmask_q[head.grp];
				hkind = KIND_VOIC_FWD;
			end
			default: ;
		endcase
		hit = hit && !done_q;
	end

	// hold the ring while a new result waits on a full output
	assign step     = (state_q == ST_SCAN) && !(hit && pv_q && !out_free);
	assign load_out = (step && hit && pv_q) || (state_q == ST_FLUSH && pv_q && out_free);

	always_comb begin
		cmd         = '0;
		cmd.grp     = source_ssrc[28:24];
		cmd.owner   = idx_w;
		cmd.mask    = gmask_q;
		if (state_q == ST_SCAN) begin
			cmd.grp  = head.grp;
			cmd.take = step && hit && op_q == OP_TALK;
		end else if (accept) begin
			cmd.tick    = (op == OP_TICK);
			cmd.refresh = (op == OP_VOICE) && src_in;
			cmd.drop    = (op == OP_STATUS) && src_in && !talk_on;
		end
	end

	ptt_floor #(.CLIENT_SLOTS(CLIENT_SLOTS), .GROUP_COUNT(GROUP_COUNT)) u_floor (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.timeout  (timeout_q),
		.head_grp (head.grp),
		.head_held(head_held),
		.src_grp  (source_ssrc[28:24]),
		.src_held (src_held),
		.src_mask (src_mask)
	);

	for (genvar j = 0; j < CLIENT_SLOTS; j++) begin : g_ring
		cell_t nxt;
		if (j == CLIENT_SLOTS - 1) begin : g_tail
			assign nxt = mod_c;
		end else begin : g_mid
			assign nxt = ring[j+1];
		end
		ptt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (step),
			.nxt   (nxt),
			.cur   (ring[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rcnt_q  <= '0;
			done_q  <= 1'b0;
			pv_q    <= 1'b0;
			ov_q    <= 1'b0;
			op_q    <= OP_JOIN;
		end else begin
			if (load_out) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= op;
						cnt_q  <= '0;
						rcnt_q <= '0;
						done_q <= 1'b0;
						if (op == OP_JOIN || op == OP_BYE || op == OP_PING || op == OP_TALK)
							state_q <= ST_SCAN;
						else if ((op == OP_STATUS || op == OP_VOICE) && src_in && src_held)
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step) begin
						if (hit) begin
							pv_q   <= 1'b1;
							rcnt_q <= rcnt_q + RCW'(1);
							if (op_q != OP_STATUS && op_q != OP_VOICE) done_q <= 1'b1;
							else if (rcnt_q == RCW'(MAX_RESULTS - 1)) done_q <= 1'b1;
						end
						if (cnt_q == CW'(CLIENT_SLOTS - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pv_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pv_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cid_q   <= client_id;
			gmask_q <= group_mask;
			fmask_q <= src_mask;
			jgrp_q  <= jgrp_c;
		end
		if (step && hit) begin
			pkind_q <= hkind;
			pid_q   <= hid;
			pslot_q <= 6'(idx);
		end
		if (load_out) begin
			okind_q <= pkind_q;
			oid_q   <= pid_q;
			oslot_q <= pslot_q;
			olast_q <= (state_q == ST_FLUSH);
		end
	end

	assign out_valid   = ov_q;
	assign kind        = okind_q;
	assign assigned_id = oid_q;
	assign dest_slot   = oslot_q;
	assign last        = olast_q;
endmodule

>>> src/ptt_checker.sv
// Port-level checker for the push-to-talk floor block, bound to the top level
`timescale 1ns / 1ps
`include "ptt_group_floor_and_fanout_assert.svh"
module ptt_checker import ptt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  op,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [31:0] assigned_id,
	input logic [5:0]  dest_slot,
	input logic        last
);
	// a stalled result holds
	`PTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dest_slot) && $stable(kind))
	// acknowledgements are single results
	`PTT_ASSERT_NOW(a_ack_last, out_valid && (kind == KIND_JOIN_ACK || kind == KIND_PING_ACK || kind == KIND_TALK_ACK), last)
	// forwards carry no id
	`PTT_ASSERT_NOW(a_fwd_id, out_valid && (kind == KIND_STAT_FWD || kind == KIND_VOIC_FWD), assigned_id == 32'd0)
	// a tick transaction finishes at once
	`PTT_ASSERT_NEXT(a_tick_quick, in_valid && !in_stall && op == OP_TICK, !in_stall)
endmodule

bind ptt_group_floor_and_fanout ptt_checker u_ptt_checker (.*);

>>> sim/tb_ptt_group_floor_and_fanout.sv
// Testbench for the push-to-talk floor block: directed table, then random checked by a predictor
`timescale 1ns / 1ps
module tb_ptt_group_floor_and_fanout;
	import ptt_pkg::*;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] cid;
		logic [31:0] ssrc;
		logic [31:0] mask;
		logic        talk;
		bit          typed;
		logic [2:0]  xkind;
		logic [31:0] xid;
		logic [5:0]  xslot;
	} pkt_t;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] id;
		logic [5:0]  slot;
		logic        last;
	} reply_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [31:0] client_id = '0;
	logic [31:0] source_ssrc = '0;
	logic [31:0] group_mask = '0;
	logic        talk_on = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  kind;
	logic [31:0] assigned_id;
	logic [5:0]  dest_slot;
	logic        last;

	ptt_group_floor_and_fanout DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .client_id(client_id),
		.source_ssrc(source_ssrc), .group_mask(group_mask), .talk_on(talk_on),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.assigned_id(assigned_id), .dest_slot(dest_slot), .last(last)
	);

	always #4 clk = ~clk;

	// predictor state
	logic        used_m [64];
	logic [31:0] ident_m [64];
	logic [4:0]  grp_m [64];
	logic [31:0] targets_m [64];
	logic        held_m [32];
	logic [5:0]  owner_m [32];
	logic [15:0] age_m [32];
	logic [15:0] timeout_m = TIMEOUT_RESET;

	reply_t      replies_q [$];
	int          fail_cnt = 0;
	int          send_idle = 30;
	int          recv_idle = 57;
	int          quiet_cycles = 0;
	logic [31:0] last_join_id = '0;

	initial begin
		for (int i = 0; i < 64; i++) begin
			used_m[i] = 0; ident_m[i] = '0; grp_m[i] = '0; targets_m[i] = '0;
		end
		for (int g = 0; g < 32; g++) begin
			held_m[g] = 0; owner_m[g] = '0; age_m[g] = '0;
		end
	end

	function automatic void add_reply(logic [2:0] k, logic [31:0] id, logic [5:0] s);
		reply_t r;
		r.kind = k; r.id = id; r.slot = s; r.last = 1'b0;
		replies_q.push_back(r);
	endfunction

	// advance the floor and table state by one transaction, queue its replies
	function automatic void predict_floor(pkt_t p);
		int          n0;
		logic [4:0]  g;
		logic [31:0] m;
		n0 = replies_q.size();
		case (p.op)
			OP_JOIN: for (int i = 0; i < 64; i++) if (!used_m[i]) begin
				used_m[i] = 1;
				ident_m[i] = {p.cid[31:24], 18'd0, 6'(i)};
				grp_m[i] = p.cid[28:24];
				last_join_id = ident_m[i];
				add_reply(KIND_JOIN_ACK, ident_m[i], 6'(i));
				break;
			end
			OP_BYE: for (int i = 0; i < 64; i++)
				if (used_m[i] && ident_m[i] == p.cid) used_m[i] = 0;
			OP_PING: for (int i = 0; i < 64; i++) if (used_m[i] && ident_m[i] == p.cid) begin
				add_reply(KIND_PING_ACK, ident_m[i], 6'(i));
				break;
			end
			OP_TALK: for (int i = 0; i < 64; i++)
				if (used_m[i] && ident_m[i] == p.cid && !held_m[grp_m[i]]) begin
					g = grp_m[i];
					held_m[g] = 1; age_m[g] = '0; owner_m[g] = 6'(i);
					targets_m[i] = p.mask;
					add_reply(KIND_TALK_ACK, ident_m[i], 6'(i));
					break;
				end
			OP_STATUS, OP_VOICE: if (p.ssrc[31:29] == 3'd0 && held_m[p.ssrc[28:24]]) begin
				g = p.ssrc[28:24];
				if (p.op == OP_VOICE) age_m[g] = '0;
				m = targets_m[owner_m[g]];
				for (int i = 0; i < 64; i++)
					if (used_m[i] && m[grp_m[i]])
						add_reply(p.op == OP_STATUS ? KIND_STAT_FWD : KIND_VOIC_FWD,
							'0, 6'(i));
				if (p.op == OP_STATUS && !p.talk) begin
					held_m[g] = 0; age_m[g] = '0;
				end
			end
			OP_TICK: for (int j = 0; j < 32; j++) if (held_m[j]) begin
				if (age_m[j] != 16'hffff) age_m[j]++;
				if (age_m[j] > timeout_m) begin
					held_m[j] = 0; age_m[j] = '0;
				end
			end
			default: ;
		endcase
		if (replies_q.size() > n0) replies_q[$].last = 1'b1;
	endfunction

	task automatic send_pkt(pkt_t p);
		int n0;
		while ($urandom_range(99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1; op = p.op; client_id = p.cid; source_ssrc = p.ssrc;
		group_mask = p.mask; talk_on = p.talk;
		do @(posedge clk); while (in_stall);
		n0 = replies_q.size();
		predict_floor(p);
		if (p.typed) begin
			while (replies_q.size() > n0) void'(replies_q.pop_back());
			add_reply(p.xkind, p.xid, p.xslot);
			replies_q[$].last = 1'b1;
		end
		@(negedge clk);
	endtask

	// write the timeout only once the block has drained
	task automatic write_timeout(logic [15:0] v);
		in_valid = 0;
		wait (replies_q.size() == 0);
		repeat (70) @(negedge clk);
		cfg_we = 1; cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		timeout_m = v;
	endtask

	function automatic logic [31:0] pick_ident();
		int idx [$];
		for (int i = 0; i < 64; i++) if (used_m[i]) idx.push_back(i);
		if (idx.size() == 0) return $urandom;
		return ident_m[idx[$urandom_range(idx.size() - 1)]];
	endfunction

	function automatic logic [7:0] pick_group();
		int idx [$];
		for (int i = 0; i < 64; i++) if (used_m[i]) idx.push_back(i);
		if (idx.size() == 0 || $urandom_range(99) < 20) return 8'($urandom);
		return {3'd0, grp_m[idx[$urandom_range(idx.size() - 1)]]};
	endfunction

	function automatic pkt_t rand_pkt(logic [2:0] force_op, bit use_force);
		pkt_t p;
		int   w;
		logic [7:0] tops [8] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h21, 8'h22, 8'hff, 8'h80};
		w = $urandom_range(99);
		p.op = w < 20 ? OP_JOIN : w < 28 ? OP_BYE : w < 40 ? OP_PING : w < 55 ? OP_TALK :
			w < 70 ? OP_STATUS : w < 85 ? OP_VOICE : w < 97 ? OP_TICK : 3'd7;
		if (use_force) p.op = force_op;
		p.cid = $urandom;
		if (p.op == OP_JOIN && $urandom_range(99) < 70) p.cid[31:24] = tops[$urandom_range(7)];
		if (p.op inside {OP_BYE, OP_PING, OP_TALK} && $urandom_range(99) < 85)
			p.cid = pick_ident();
		p.ssrc = $urandom;
		if (p.op inside {OP_STATUS, OP_VOICE}) p.ssrc[31:24] = pick_group();
		p.mask = $urandom_range(3) == 0 ? 32'hffffffff : $urandom;
		p.talk = $urandom_range(1);
		p.typed = 0; p.xkind = '0; p.xid = '0; p.xslot = '0;
		return p;
	endfunction

	// receiver stall
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replies_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0d id=%h slot=%0d last=%0b",
					$time, kind, assigned_id, dest_slot, last);
				fail_cnt++;
			end else begin
				reply_t e;
				e = replies_q.pop_front();
				if (kind !== e.kind || assigned_id !== e.id || dest_slot !== e.slot ||
						last !== e.last) begin
					$display("%0t: mismatch expected kind=%0d id=%h slot=%0d last=%0b",
						$time, e.kind, e.id, e.slot, e.last);
					$display("%0t:          actual   kind=%0d id=%h slot=%0d last=%0b",
						$time, kind, assigned_id, dest_slot, last);
					fail_cnt++;
				end
			end
		end
	end

	// count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("ptt_group_floor_and_fanout test failed");
			$finish;
		end
	end

	pkt_t table_rows [23] = '{
		'{OP_JOIN,   32'h05123456, 32'h0, 32'h0, 1'b0, 1, KIND_JOIN_ACK, 32'h05000000, 6'd0},
		'{OP_JOIN,   32'hffffffff, 32'h0, 32'h0, 1'b0, 1, KIND_JOIN_ACK, 32'hff000001, 6'd1},
		'{OP_JOIN,   32'h25000000, 32'h0, 32'h0, 1'b0, 1, KIND_JOIN_ACK, 32'h25000002, 6'd2},
		'{OP_JOIN,   32'h00000000, 32'h0, 32'h0, 1'b0, 1, KIND_JOIN_ACK, 32'h00000003, 6'd3},
		'{OP_PING,   32'h05000000, 32'h0, 32'h0, 1'b0, 1, KIND_PING_ACK, 32'h05000000, 6'd0},
		'{OP_PING,   32'h12345678, 32'h0, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 0, 3'd0, 32'h0, 6'd0},
		'{OP_TALK, 32'h05000000, 32'h0, 32'hffffffff, 1'b0, 1, KIND_TALK_ACK, 32'h05000000,
			6'd0},
		'{OP_TALK,   32'h25000002, 32'h0, 32'h1, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_VOICE,  32'h0, 32'h05abcdef, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_STATUS, 32'h0, 32'h25000000, 32'h0, 1'b1, 0, 3'd0, 32'h0, 6'd0},
		'{OP_STATUS, 32'h0, 32'h1f000000, 32'h0, 1'b1, 0, 3'd0, 32'h0, 6'd0},
		'{OP_TALK, 32'hff000001, 32'h0, 32'h80000021, 1'b0, 1, KIND_TALK_ACK, 32'hff000001,
			6'd1},
		'{OP_BYE,    32'hff000001, 32'h0, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_STATUS, 32'h0, 32'h1fffffff, 32'h0, 1'b1, 0, 3'd0, 32'h0, 6'd0},
		'{OP_STATUS, 32'h0, 32'h1f000000, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_STATUS, 32'h0, 32'h1f000000, 32'h0, 1'b1, 0, 3'd0, 32'h0, 6'd0},
		'{OP_TICK,   32'h0, 32'h0, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_BYE,    32'hdeadbeef, 32'h0, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_JOIN,   32'h80000000, 32'h0, 32'h0, 1'b0, 1, KIND_JOIN_ACK, 32'h80000001, 6'd1},
		'{OP_STATUS, 32'h0, 32'h05000000, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0},
		'{OP_TALK, 32'h25000002, 32'h0, 32'h0, 1'b0, 1, KIND_TALK_ACK, 32'h25000002, 6'd2},
		'{OP_VOICE,  32'h0, 32'h05000000, 32'h0, 1'b0, 0, 3'd0, 32'h0, 6'd0}
	};

	initial begin
		pkt_t p;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (table_rows[r]) send_pkt(table_rows[r]);

		write_timeout(16'd3);
		repeat (20) send_pkt(rand_pkt(OP_JOIN, 0));

		send_idle = 57; recv_idle = 30;
		write_timeout(16'd0);
		// fill the table past capacity
		repeat (66) send_pkt(rand_pkt(OP_JOIN, 1));
		repeat (15) send_pkt(rand_pkt(OP_JOIN, 0));

		send_idle = 0; recv_idle = 0;
		write_timeout(16'hffff);
		repeat (17) send_pkt(rand_pkt(OP_JOIN, 0));
		// take a floor, age it, then speak on it
		p = rand_pkt(OP_JOIN, 1);
		p.cid[31:24] = 8'h07;
		send_pkt(p);
		p = rand_pkt(OP_TALK, 1);
		p.cid = last_join_id;
		send_pkt(p);
		p = rand_pkt(OP_TICK, 1);
		repeat (4) send_pkt(p);
		p = rand_pkt(OP_VOICE, 1);
		p.ssrc[31:24] = 8'h07;
		send_pkt(p);
		in_valid = 0;

		wait (replies_q.size() == 0);
		repeat (100) @(posedge clk);
		if (fail_cnt == 0)
			$display("ptt_group_floor_and_fanout test passed");
		else
			$display("ptt_group_floor_and_fanout test failed");
		$finish;
	end
endmodule

>>> files.f
+incdir+src
src/ptt_pkg.sv
src/ptt_cell.sv
src/ptt_floor.sv
src/ptt_group_floor_and_fanout.sv
src/ptt_checker.sv
sim/tb_ptt_group_floor_and_fanout.sv
